// File: sv/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
package psu_pkg;

  // Widest column index the entry format carries (MAX_ROW_BYTES up to 65536).
  localparam int COL_W = 16;

  // Front-to-back queue depth.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int ROW_BYTES_W = 13;
  localparam int STRIDE_W    = 4;
  localparam int WIN_DEPTH   = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROW_BYTES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PIXEL_STRIDE = 2'd1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       image_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       bad_filter_seen;
  } out_item_t;

  // One classified data byte on its way from the front to the back.
  typedef struct packed {
    logic [7:0]       data;
    filt_e            filter;
    logic [COL_W-1:0] col;
    logic             row_start;
    logic             first_row;
    logic             row_end;
    logic             err;
  } entry_t;

endpackage

// File: sv/psu_front.sv
// Front end: accepts stream bytes, decodes filter types and tracks row position.
module psu_front #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [psu_pkg::ROW_BYTES_W-1:0]   cfg_row_bytes_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  psu_pkg::in_item_t                 in_data_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output psu_pkg::entry_t                   q_entry_o
);

  localparam int CW = $clog2(MAX_ROW_BYTES);
  localparam int RW = (CW + 1 > psu_pkg::ROW_BYTES_W) ? CW + 1 : psu_pkg::ROW_BYTES_W;

  logic [CW-1:0]   col_q, col_d;
  psu_pkg::filt_e  filter_q, filter_d;
  logic            awaiting_q, awaiting_d;
  logic            first_q, first_d;
  logic            err_q, err_d;

  logic            accept;
  logic            awaiting_eff, first_eff, err_eff;
  logic [CW-1:0]   col_eff;
  logic [RW-1:0]   rb_raw, rb_eff, next_col;
  logic            last;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Clamp the row length into 1..MAX_ROW_BYTES.
  always_comb begin
    rb_raw = RW'(cfg_row_bytes_i);
    if (rb_raw == '0) begin
      rb_eff = RW'(1);
    end else if (rb_raw > RW'(MAX_ROW_BYTES)) begin
      rb_eff = RW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_raw;
    end
  end

  always_comb begin
    awaiting_eff = in_data_i.image_start || awaiting_q;
    first_eff    = in_data_i.image_start || first_q;
    err_eff      = in_data_i.image_start ? 1'b0 : err_q;
    col_eff      = in_data_i.image_start ? '0 : col_q;
    next_col     = RW'(col_eff) + RW'(1);
    last         = next_col >= rb_eff;

    col_d      = col_q;
    filter_d   = filter_q;
    awaiting_d = awaiting_q;
    first_d    = first_q;
    err_d      = err_q;
    q_push_o   = 1'b0;

    q_entry_o.data      = in_data_i.stream_byte;
    q_entry_o.filter    = filter_q;
    q_entry_o.col       = psu_pkg::COL_W'(col_eff);
    q_entry_o.row_start = (col_eff == '0);
    q_entry_o.first_row = first_eff;
    q_entry_o.row_end   = last;
    q_entry_o.err       = err_eff;

    if (accept) begin
      if (awaiting_eff) begin
        if (in_data_i.stream_byte <= 8'd4) begin
          filter_d = psu_pkg::filt_e'(in_data_i.stream_byte[2:0]);
          err_d    = err_eff;
        end else begin
          filter_d = psu_pkg::FILT_BAD;
          err_d    = 1'b1;
        end
        col_d      = '0;
        awaiting_d = 1'b0;
        first_d    = first_eff;
      end else begin
        q_push_o   = 1'b1;
        err_d      = err_eff;
        awaiting_d = last;
        first_d    = last ? 1'b0 : first_eff;
        col_d      = last ? '0 : next_col[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      filter_q   <= psu_pkg::FILT_NONE;
      awaiting_q <= 1'b1;
      first_q    <= 1'b1;
      err_q      <= 1'b0;
    end else begin
      col_q      <= col_d;
      filter_q   <= filter_d;
      awaiting_q <= awaiting_d;
      first_q    <= first_d;
      err_q      <= err_d;
    end
  end

endmodule

// File: sv/psu_queue.sv
// Short FIFO of classified data bytes between the front and the back.
module psu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  psu_pkg::entry_t push_data_i,
  output logic            full_o,
  output logic            valid_o,
  output psu_pkg::entry_t pop_data_o,
  input  logic            pop_i
);

  psu_pkg::entry_t                 slots_q [psu_pkg::QDEPTH];
  logic [psu_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [psu_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  assign full_o     = (cnt_q == psu_pkg::QCNT_W'(psu_pkg::QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + psu_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - psu_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + psu_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + psu_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/psu_back.sv
// Back end: prior-row memory, neighbour windows, filter reconstruction, output register.
module psu_back #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [psu_pkg::STRIDE_W-1:0]   cfg_stride_i,
  input  logic                           q_valid_i,
  input  psu_pkg::entry_t                q_entry_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output psu_pkg::out_item_t             out_data_o
);

  localparam int CW = $clog2(MAX_ROW_BYTES);

  logic [7:0]          mem_q [MAX_ROW_BYTES];
  logic [7:0]          rd_q;
  logic                fwd_q;
  logic [7:0]          fwd_data_q;

  logic [7:0]          left_q [psu_pkg::WIN_DEPTH];
  logic [7:0]          ul_q   [psu_pkg::WIN_DEPTH];

  logic                s1_valid_q;
  psu_pkg::entry_t     s1_q;
  logic                s1_adv;

  logic                out_valid_q;
  psu_pkg::out_item_t  out_q;

  logic [2:0]          tap;
  logic [7:0]          a, b, c, v, pred;
  logic [8:0]          ab_sum, c_dbl, pc;
  logic [7:0]          pa, pb;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign q_pop_o     = q_valid_i && (!s1_valid_q || s1_adv);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stride 0 acts as 1, above 8 acts as 8.
  always_comb begin
    if (cfg_stride_i == '0) begin
      tap = 3'd0;
    end else if (cfg_stride_i > 4'd8) begin
      tap = 3'd7;
    end else begin
      tap = 3'(cfg_stride_i - 4'd1);
    end
  end

  always_comb begin
    a = s1_q.row_start ? 8'd0 : left_q[tap];
    c = s1_q.row_start ? 8'd0 : ul_q[tap];
    if (s1_q.first_row) begin
      b = 8'd0;
    end else begin
      b = fwd_q ? fwd_data_q : rd_q;
    end

    pa     = (b > c) ? (b - c) : (c - b);
    pb     = (a > c) ? (a - c) : (c - a);
    ab_sum = {1'b0, a} + {1'b0, b};
    c_dbl  = {c, 1'b0};
    pc     = (ab_sum > c_dbl) ? (ab_sum - c_dbl) : (c_dbl - ab_sum);

    if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
      pred = a;
    end else if ({1'b0, pb} <= pc) begin
      pred = b;
    end else begin
      pred = c;
    end

    case (s1_q.filter)
      psu_pkg::FILT_NONE:  v = s1_q.data;
      psu_pkg::FILT_SUB:   v = s1_q.data + a;
      psu_pkg::FILT_UP:    v = s1_q.data + b;
      psu_pkg::FILT_AVG:   v = s1_q.data + ab_sum[8:1];
      psu_pkg::FILT_PAETH: v = s1_q.data + pred;
      default:             v = b;
    endcase
  end

  // Prior-row store: read on pop, write when the byte leaves the compute stage.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_q[s1_q.col[CW-1:0]] <= v;
    end
    if (q_pop_o) begin
      rd_q       <= mem_q[q_entry_i.col[CW-1:0]];
      fwd_data_q <= v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      for (int i = 0; i < psu_pkg::WIN_DEPTH; i++) begin
        left_q[i] <= 8'd0;
        ul_q[i]   <= 8'd0;
      end
    end else begin
      // Bypass the store when the next byte reads the column being written now.
      if (q_pop_o) begin
        fwd_q <= s1_adv && (s1_q.col == q_entry_i.col);
      end
      if (q_pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (s1_adv) begin
        left_q[0] <= v;
        ul_q[0]   <= b;
        for (int i = 1; i < psu_pkg::WIN_DEPTH; i++) begin
          left_q[i] <= s1_q.row_start ? 8'd0 : left_q[i-1];
          ul_q[i]   <= s1_q.row_start ? 8'd0 : ul_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_q <= q_entry_i;
    end
    if (s1_adv) begin
      out_q.pixel_byte      <= v;
      out_q.row_end         <= s1_q.row_end;
      out_q.bad_filter_seen <= s1_q.err;
    end
  end

endmodule

// File: sv/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: configuration registers and block wiring.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o   in_data_i  (stream_byte, image_start)
//   out      output     out_valid_o / out_ready_i out_data_o (pixel_byte, row_end,
//                                                             bad_filter_seen)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while out_ready_i stays high; a data byte passes the queue
// write, then the store read into the compute stage, then the output register.
// Type bytes produce no output but each takes an input handshake.
// Reset clears row state and sets row_bytes and pixel_stride to 1; the prior-row
// store needs no clearing since the first row never reads it.
// A stalled output fills the output register, compute stage and queue before in_ready_o drops.
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  psu_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output psu_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic [psu_pkg::ROW_BYTES_W-1:0] row_bytes_q;
  logic [psu_pkg::STRIDE_W-1:0]    pixel_stride_q;

  logic            q_push, q_full, q_valid, q_pop;
  psu_pkg::entry_t q_push_data, q_pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q    <= psu_pkg::ROW_BYTES_W'(1);
      pixel_stride_q <= psu_pkg::STRIDE_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        psu_pkg::CFG_IDX_ROW_BYTES:    row_bytes_q    <= cfg_data_i;
        psu_pkg::CFG_IDX_PIXEL_STRIDE: pixel_stride_q <= cfg_data_i[psu_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  psu_front #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_row_bytes_i(row_bytes_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_push_data)
  );

  psu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_data_o (q_pop_data),
    .pop_i      (q_pop)
  );

  psu_back #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_stride_i(pixel_stride_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
